/* sv/sparse_markov_chain_sampler_macros.svh */
// ----------------------------------------------------------------------------
// sparse markov chain sampler assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef SPARSE_MARKOV_CHAIN_SAMPLER_MACROS_SVH
`define SPARSE_MARKOV_CHAIN_SAMPLER_MACROS_SVH

// property checked outside reset
`define SMCS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define SMCS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/smcs_pkg.sv */
// ----------------------------------------------------------------------------
// smcs_pkg
// shared sizes, codes and controller/datapath types of the chain sampler
// ----------------------------------------------------------------------------
`default_nettype none

package smcs_pkg;

   localparam int MAX_STATES  = 256;
   localparam int MAX_ENTRIES = 4096;
   localparam int FRAC_BITS   = 16;

   localparam int ST_AW   = $clog2(MAX_STATES);
   localparam int EN_AW   = $clog2(MAX_ENTRIES);
   localparam int EN_CW   = EN_AW + 1;
   localparam int PROB_W  = FRAC_BITS + 1;
   localparam int ENTRY_W = PROB_W + ST_AW;

   typedef enum logic [1:0] {
      OP_WRITE_ENTRY = 2'd0,
      OP_WRITE_ROW   = 2'd1,
      OP_START       = 2'd2,
      OP_STEP        = 2'd3
   } op_type;

   localparam logic [1:0] CSR_NUM_STATES  = 2'd0;
   localparam logic [1:0] CSR_NUM_ENTRIES = 2'd1;
   localparam logic [1:0] CSR_STEPS       = 2'd2;
   localparam logic [1:0] CSR_HISTORY     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW_LO,
      ST_ROW_HI,
      ST_ROW_END,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic write_entry;
      logic write_row;
      logic start;
      logic load_u;
      logic row_addr_hi;
      logic latch_start;
      logic latch_end;
      logic scan;
      logic commit;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic past_count;
      logic row_empty;
      logic hit;
      logic want;
   } status_type;

endpackage

`default_nettype wire

/* sv/smcs_ram.sv */
// ----------------------------------------------------------------------------
// smcs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module smcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/smcs_ctrl.sv */
// ----------------------------------------------------------------------------
// smcs_ctrl
// sequencer: decodes items, walks row lookup and entry scan, owns result valid
// ----------------------------------------------------------------------------
`default_nettype none

module smcs_ctrl import smcs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_WRITE_ENTRY: cmd.write_entry = 1'b1;
                  OP_WRITE_ROW:   cmd.write_row = 1'b1;
                  OP_START: begin
                     cmd.start = 1'b1;
                     state_in  = ST_EMIT;
                  end
                  OP_STEP: begin
                     // steps beyond the chain length are dropped
                     if (!status.past_count) begin
                        cmd.load_u = 1'b1;
                        state_in   = ST_ROW_LO;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW_LO: begin
            state_in = ST_ROW_HI;
         end
         ST_ROW_HI: begin
            cmd.latch_start = 1'b1;
            cmd.row_addr_hi = 1'b1;
            state_in        = ST_ROW_END;
         end
         ST_ROW_END: begin
            cmd.latch_end = 1'b1;
            if (status.row_empty) begin
               cmd.commit = 1'b1;
               state_in   = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.hit) begin
               cmd.commit = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.want) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

/* sv/smcs_datapath.sv */
// ----------------------------------------------------------------------------
// smcs_datapath
// matrix stores, config registers, chain state, row scan and result register
// ----------------------------------------------------------------------------
`default_nettype none

module smcs_datapath import smcs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic [11:0] req_index,
   input  wire logic [16:0] req_prob,
   input  wire logic [11:0] req_value,
   input  wire logic [15:0] req_uniform,
   input  wire cmd_type     cmd,
   output status_type       status,
   output logic [7:0]       rsp_position,
   output logic [15:0]      rsp_step_count,
   output logic             rsp_last,
   output logic             rsp_row_empty
);

   // configuration
   logic [8:0]  num_states_ff;
   logic [12:0] num_entries_ff;
   logic [15:0] steps_cfg_ff;
   logic        history_ff;

   // chain state
   logic [ST_AW-1:0]     cur_ff, cur_in;
   logic [15:0]          steps_ff, steps_in;

   // step working registers
   logic [FRAC_BITS-1:0] rem_ff, rem_in;
   logic [EN_CW-1:0]     start_ff, start_in;
   logic [EN_CW-1:0]     end_ff, end_in;
   logic [EN_CW-1:0]     ptr_ff, ptr_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic                 chk_last_ff, chk_last_in;

   // pending result
   logic [ST_AW-1:0]     res_pos_ff, res_pos_in;
   logic [15:0]          res_cnt_ff, res_cnt_in;
   logic                 res_last_ff, res_last_in;
   logic                 res_empty_ff, res_empty_in;
   logic                 want_ff, want_in;

   // output register
   logic [ST_AW-1:0]     out_pos_ff;
   logic [15:0]          out_cnt_ff;
   logic                 out_last_ff, out_empty_ff;

   // stores
   logic                 row_we, ent_we;
   logic [ST_AW-1:0]     row_raddr;
   logic [EN_CW-1:0]     row_rd;
   logic [ENTRY_W-1:0]   ent_wdata, ent_rd;

   logic [PROB_W-1:0]    ent_prob;
   logic [ST_AW-1:0]     ent_col;
   logic                 use_next;
   logic [EN_CW-1:0]     end_raw, end_clamp, start_clamp;
   logic                 issuing, hit_now;
   logic [15:0]          steps_inc;

   assign row_we    = cmd.write_row && (32'(req_index) < MAX_STATES);
   assign ent_we    = cmd.write_entry && (32'(req_index) < MAX_ENTRIES);
   assign ent_wdata = {req_prob[PROB_W-1:0], req_value[ST_AW-1:0]};
   assign row_raddr = cmd.row_addr_hi ? cur_ff + ST_AW'(1) : cur_ff;

   smcs_ram #(.WIDTH(EN_CW), .DEPTH(MAX_STATES)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (req_index[ST_AW-1:0]),
      .wr_data (EN_CW'(req_value)),
      .rd_addr (row_raddr),
      .rd_data (row_rd)
   );

   smcs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (req_index[EN_AW-1:0]),
      .wr_data (ent_wdata),
      .rd_addr (ptr_ff[EN_AW-1:0]),
      .rd_data (ent_rd)
   );

   assign ent_prob = ent_rd[ENTRY_W-1:ST_AW];
   assign ent_col  = ent_rd[ST_AW-1:0];

   // the last row, or a row past num_states, ends at num_entries
   assign use_next = (32'(cur_ff) + 1 < 32'(num_states_ff)) &&
                     (32'(cur_ff) + 1 < MAX_STATES);
   assign end_raw     = use_next ? row_rd : num_entries_ff;
   assign end_clamp   = (32'(end_raw) > MAX_ENTRIES) ? EN_CW'(MAX_ENTRIES) : end_raw;
   assign start_clamp = (32'(row_rd) > MAX_ENTRIES) ? EN_CW'(MAX_ENTRIES) : row_rd;

   assign issuing = cmd.scan && (ptr_ff < end_ff);
   // the row's final entry is taken when u exceeds the row sum
   assign hit_now = chk_valid_ff &&
                    ((ent_prob >= PROB_W'(rem_ff)) || chk_last_ff);
   assign steps_inc = steps_ff + 16'd1;

   assign status.past_count = steps_ff >= steps_cfg_ff;
   assign status.row_empty  = end_clamp <= start_ff;
   assign status.hit        = hit_now;
   assign status.want       = want_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_states_ff  <= 9'd256;
         num_entries_ff <= 13'd4096;
         steps_cfg_ff   <= 16'd1;
         history_ff     <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_NUM_STATES:  num_states_ff  <= csr_data[8:0];
            CSR_NUM_ENTRIES: num_entries_ff <= csr_data[12:0];
            CSR_STEPS:       steps_cfg_ff   <= csr_data;
            CSR_HISTORY:     history_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      steps_in     = steps_ff;
      rem_in       = rem_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      ptr_in       = ptr_ff;
      chk_valid_in = issuing;
      chk_last_in  = (ptr_ff + EN_CW'(1)) == end_ff;
      res_pos_in   = res_pos_ff;
      res_cnt_in   = res_cnt_ff;
      res_last_in  = res_last_ff;
      res_empty_in = res_empty_ff;
      want_in      = want_ff;

      if (cmd.start) begin
         cur_in       = req_value[ST_AW-1:0];
         steps_in     = 16'd0;
         res_pos_in   = req_value[ST_AW-1:0];
         res_cnt_in   = 16'd0;
         res_last_in  = steps_cfg_ff == 16'd0;
         res_empty_in = 1'b0;
         want_in      = history_ff || (steps_cfg_ff == 16'd0);
      end
      if (cmd.load_u) begin
         rem_in = req_uniform[FRAC_BITS-1:0];
      end
      if (cmd.latch_start) begin
         start_in = start_clamp;
      end
      if (cmd.latch_end) begin
         end_in = end_clamp;
         ptr_in = start_ff;
      end
      if (issuing) begin
         ptr_in = ptr_ff + EN_CW'(1);
      end
      if (cmd.scan && chk_valid_ff && !hit_now) begin
         // entry probability is below the remainder here
         rem_in = rem_ff - ent_prob[FRAC_BITS-1:0];
      end
      if (cmd.commit) begin
         cur_in       = hit_now ? ent_col : cur_ff;
         steps_in     = steps_inc;
         res_pos_in   = hit_now ? ent_col : cur_ff;
         res_cnt_in   = steps_inc;
         res_last_in  = steps_inc == steps_cfg_ff;
         res_empty_in = !hit_now;
         want_in      = history_ff || (steps_inc == steps_cfg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         steps_ff     <= '0;
         chk_valid_ff <= 1'b0;
         want_ff      <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         steps_ff     <= steps_in;
         chk_valid_ff <= chk_valid_in;
         want_ff      <= want_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff       <= rem_in;
      start_ff     <= start_in;
      end_ff       <= end_in;
      ptr_ff       <= ptr_in;
      chk_last_ff  <= chk_last_in;
      res_pos_ff   <= res_pos_in;
      res_cnt_ff   <= res_cnt_in;
      res_last_ff  <= res_last_in;
      res_empty_ff <= res_empty_in;
      if (cmd.out_load) begin
         out_pos_ff   <= res_pos_ff;
         out_cnt_ff   <= res_cnt_ff;
         out_last_ff  <= res_last_ff;
         out_empty_ff <= res_empty_ff;
      end
   end

   assign rsp_position   = 8'(out_pos_ff);
   assign rsp_step_count = out_cnt_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_row_empty  = out_empty_ff;

endmodule

`default_nettype wire

/* sv/sparse_markov_chain_sampler.sv */
// One item is in flight at a time. A write, or a step past the chain length, is handled in the
// idle state; a start item goes to the emit state, which puts its result in the output register
// once it is free. A step walks the row lo, row hi and row end states, then scans the row up to
// the chosen entry, one entry ram read per cycle, and emits; an empty row skips the scan.
// Reset is synchronous: chain state, configuration and result valid return to defaults;
// the matrix stores are not cleared and must be written before use.
// ----------------------------------------------------------------------------
// sparse_markov_chain_sampler
// sparse transition matrix stores and inverse cdf sampling of chain steps
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_markov_chain_sampler import smcs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [11:0] req_index,
   input  wire logic [16:0] req_prob,
   input  wire logic [11:0] req_value,
   input  wire logic [15:0] req_uniform,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_position,
   output logic [15:0]      rsp_step_count,
   output logic             rsp_last,
   output logic             rsp_row_empty
);

   cmd_type    cmd;
   status_type status;

   smcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   smcs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_index      (req_index),
      .req_prob       (req_prob),
      .req_value      (req_value),
      .req_uniform    (req_uniform),
      .cmd            (cmd),
      .status         (status),
      .rsp_position   (rsp_position),
      .rsp_step_count (rsp_step_count),
      .rsp_last       (rsp_last),
      .rsp_row_empty  (rsp_row_empty)
   );

endmodule

`default_nettype wire

/* sv/smcs_checker.sv */
// ----------------------------------------------------------------------------
// smcs_checker
// port level checks of the chain sampler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_markov_chain_sampler_macros.svh"

module smcs_checker import smcs_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_op,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_position,
   input wire logic [15:0] rsp_step_count,
   input wire logic        rsp_row_empty
);

   // stalled result stays offered
   `SMCS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position), "stalled result dropped or changed")

   // no result survives reset
   `SMCS_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid, "result valid after reset")

   // an empty row only comes from a step
   `SMCS_ASSERT(a_empty_step, clock, reset, rsp_valid && rsp_row_empty |-> rsp_step_count != 16'd0, "empty row flag on a start result")

   // a start item holds the input while its result is settled
   `SMCS_ASSERT(a_start_busy, clock, reset, req_valid && !req_stall && req_op == OP_START |=> req_stall, "item taken right after a start")

endmodule

bind sparse_markov_chain_sampler smcs_checker u_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sparse markov chain sampler: loads transition
// matrices, runs start/step items under random sender gaps and receiver
// stalls, and checks every result against an inverse cdf walk of its own
// ----------------------------------------------------------------------------
module tb import smcs_pkg::*; ();

   localparam int CLOCK_PERIOD  = 20;
   localparam int SETTLE_CYCLES = 1000;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct packed {
      op_type      op;
      logic [11:0] index;
      logic [16:0] prob;
      logic [11:0] value;
      logic [15:0] uniform;
   } chain_item_type;

   typedef struct packed {
      logic [7:0]  position;
      logic [15:0] step_count;
      logic        last;
      logic        row_empty;
   } chain_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [11:0] req_index = '0;
   logic [16:0] req_prob = '0;
   logic [11:0] req_value = '0;
   logic [15:0] req_uniform = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_position;
   logic [15:0] rsp_step_count;
   logic        rsp_last;
   logic        rsp_row_empty;

   sparse_markov_chain_sampler dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_index      (req_index),
      .req_prob       (req_prob),
      .req_value      (req_value),
      .req_uniform    (req_uniform),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position   (rsp_position),
      .rsp_step_count (rsp_step_count),
      .rsp_last       (rsp_last),
      .rsp_row_empty  (rsp_row_empty)
   );

   // predictor copy of the matrix, chain and registers
   logic [16:0] prob_mem [0:MAX_ENTRIES-1];
   logic [7:0]  col_mem  [0:MAX_ENTRIES-1];
   logic [12:0] row_mem  [0:MAX_STATES-1];
   logic [7:0]  chain_pos = '0;
   logic [15:0] chain_steps = '0;
   logic [8:0]  cfg_states = 9'd256;
   logic [12:0] cfg_entries = 13'd4096;
   logic [15:0] cfg_steps = 16'd1;
   logic        cfg_history = 1'b0;

   chain_item_type   pending_requests [$];
   chain_result_type expected_states [$];

   int error_count = 0;
   int cycle_count = 0;
   logic req_taken = 1'b0;
   int idle_left = 0;
   int burst_left = 1;
   int stall_hold = 0;
   int stall_style = 0;
   int stall_tick = 0;

   // layout of the matrix loaded for the current phase
   int phase_low = 0;
   int phase_states = 256;
   int phase_base = 0;
   int phase_end = 0;

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 50)
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                  want);
      error_count++;
   endtask

   function automatic bit advance_chain(input chain_item_type it,
                                        output chain_result_type res);
      int unsigned cur, row_lo, row_hi, k, rem;
      bit empty, found, ends;
      logic [7:0] next_pos;
      res = '0;
      advance_chain = 1'b0;
      case (it.op)
         OP_WRITE_ENTRY: begin
            prob_mem[it.index] = it.prob;
            col_mem[it.index] = it.value[7:0];
         end
         OP_WRITE_ROW: begin
            if (32'(it.index) < MAX_STATES)
               row_mem[it.index[7:0]] = {1'b0, it.value};
         end
         OP_START: begin
            ends = (cfg_steps == 16'd0);
            chain_pos = it.value[7:0];
            chain_steps = '0;
            if (cfg_history || ends) begin
               res.position = chain_pos;
               res.last = ends;
               advance_chain = 1'b1;
            end
         end
         default: begin
            if (chain_steps < cfg_steps) begin
               cur = 32'(chain_pos);
               row_lo = 32'(row_mem[cur]);
               if (cur + 1 < 32'(cfg_states) && cur + 1 < MAX_STATES)
                  row_hi = 32'(row_mem[cur + 1]);
               else
                  row_hi = 32'(cfg_entries);
               if (row_lo > MAX_ENTRIES) row_lo = MAX_ENTRIES;
               if (row_hi > MAX_ENTRIES) row_hi = MAX_ENTRIES;
               empty = (row_hi <= row_lo);
               next_pos = chain_pos;
               if (!empty) begin
                  // inverse cdf walk, first entry whose probability covers what is left of u
                  rem = 32'(it.uniform);
                  found = 1'b0;
                  k = row_lo;
                  while (!found && k < row_hi) begin
                     if (32'(prob_mem[k]) >= rem) begin
                        next_pos = col_mem[k];
                        found = 1'b1;
                     end else begin
                        rem = rem - 32'(prob_mem[k]);
                        k++;
                     end
                  end
                  if (!found)
                     next_pos = col_mem[row_hi - 1];
               end
               chain_pos = next_pos;
               chain_steps = chain_steps + 16'd1;
               ends = (chain_steps == cfg_steps);
               if (cfg_history || ends) begin
                  res.position = chain_pos;
                  res.step_count = chain_steps;
                  res.last = ends;
                  res.row_empty = empty;
                  advance_chain = 1'b1;
               end
            end
         end
      endcase
   endfunction

   // sender: bursts of items separated by random gaps
   always @(negedge clock) begin : drive_requests
      chain_item_type next_item;
      if (!reset && (!req_valid || req_taken)) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            next_item = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_op <= next_item.op;
            req_index <= next_item.index;
            req_prob <= next_item.prob;
            req_value <= next_item.value;
            req_uniform <= next_item.uniform;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               idle_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall style is redrawn whenever its hold count runs out
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_hold <= $urandom_range(20, 200);
      end else begin
         stall_hold <= stall_hold - 1;
      end
      stall_tick <= stall_tick + 1;
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         2: rsp_stall <= (stall_tick % 8) < 3;
         default: rsp_stall <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin : watch_ports
      chain_item_type   seen;
      chain_result_type outcome;
      chain_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            seen.op = op_type'(req_op);
            seen.index = req_index;
            seen.prob = req_prob;
            seen.value = req_value;
            seen.uniform = req_uniform;
            if (advance_chain(seen, outcome))
               expected_states.push_back(outcome);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               report_mismatch("result with none pending, position", int'(rsp_position), 0);
            end else begin
               want = expected_states.pop_front();
               if (rsp_position !== want.position)
                  report_mismatch("position", int'(rsp_position), int'(want.position));
               if (rsp_step_count !== want.step_count)
                  report_mismatch("step_count", int'(rsp_step_count), int'(want.step_count));
               if (rsp_last !== want.last)
                  report_mismatch("last", int'(rsp_last), int'(want.last));
               if (rsp_row_empty !== want.row_empty)
                  report_mismatch("row_empty", int'(rsp_row_empty), int'(want.row_empty));
            end
         end
      end
   end

   task automatic push_item(input op_type op, input int index, input int prob,
                            input int value, input int uniform);
      chain_item_type it;
      it.op = op;
      it.index = index[11:0];
      it.prob = prob[16:0];
      it.value = value[11:0];
      it.uniform = uniform[15:0];
      pending_requests.push_back(it);
   endtask

   function automatic int rand_prob();
      case ($urandom_range(0, 9))
         0: rand_prob = 0;
         1: rand_prob = 65536;
         default: rand_prob = $urandom_range(0, 65536);
      endcase
   endfunction

   function automatic int rand_uniform();
      case ($urandom_range(0, 9))
         0: rand_uniform = 0;
         1: rand_uniform = 65535;
         default: rand_uniform = $urandom_range(0, 65535);
      endcase
   endfunction

   // a state of this phase, with random bits above the low byte
   function automatic int rand_state_value();
      rand_state_value = ($urandom_range(0, 15) << 8) |
                         $urandom_range(phase_low, phase_states - 1);
   endfunction

   task automatic write_csr(input logic [1:0] idx, input int data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data[15:0];
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_NUM_STATES:  cfg_states = data[8:0];
         CSR_NUM_ENTRIES: cfg_entries = data[12:0];
         CSR_STEPS:       cfg_steps = data[15:0];
         default:         cfg_history = data[0];
      endcase
   endtask

   task automatic configure(input int states, input int entries, input int steps,
                            input int history);
      write_csr(CSR_NUM_STATES, states);
      write_csr(CSR_NUM_ENTRIES, entries);
      write_csr(CSR_STEPS, steps);
      write_csr(CSR_HISTORY, history);
   endtask

   // rows first..n-1 packed back to back so the matrix ends exactly at top
   task automatic load_matrix(input int first, input int n, input int maxlen, input int top);
      int row_len [MAX_STATES];
      int total, pos, r, k, style, left, p;
      total = 0;
      for (r = first; r < n; r++) begin
         row_len[r] = $urandom_range(0, maxlen);
         if (r == n - 1 && row_len[r] == 0)
            row_len[r] = 1;
         total += row_len[r];
      end
      phase_low = first;
      phase_states = n;
      phase_base = top - total;
      phase_end = top;
      pos = phase_base;
      for (r = first; r < n; r++) begin
         push_item(OP_WRITE_ROW, r, $urandom, pos, $urandom);
         style = $urandom_range(0, 2);
         left = 65536;
         for (k = 0; k < row_len[r]; k++) begin
            if (style == 0) begin
               // probabilities sum to exactly one
               p = (k == row_len[r] - 1) ? left : $urandom_range(0, left);
               left -= p;
            end else if (style == 1) begin
               p = rand_prob();
            end else begin
               p = $urandom_range(0, 8000);
            end
            push_item(OP_WRITE_ENTRY, pos, p, rand_state_value(), $urandom);
            pos++;
         end
      end
   endtask

   task automatic queue_chains(input int count);
      int added, pick, len, hi, k;
      added = 0;
      // every phase opens with a start so no step runs from a stale state
      push_item(OP_START, $urandom, $urandom, rand_state_value(), $urandom);
      while (added < count) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            push_item(OP_WRITE_ENTRY, $urandom_range(phase_base, phase_end - 1), rand_prob(),
                      rand_state_value(), $urandom);
            added++;
         end else if (pick == 1) begin
            // any start inside the loaded span keeps every read on written entries
            hi = (phase_end > 4095) ? 4095 : phase_end;
            push_item(OP_WRITE_ROW, $urandom_range(phase_low, phase_states - 1), $urandom,
                      $urandom_range(phase_base, hi), $urandom);
            added++;
         end else if (pick == 2) begin
            push_item(OP_WRITE_ROW, $urandom_range(MAX_STATES, 4095), $urandom, $urandom,
                      $urandom);
            added++;
         end else if (pick <= 4) begin
            push_item(OP_STEP, $urandom, $urandom, $urandom, rand_uniform());
            added++;
         end else if (pick == 5) begin
            push_item(OP_START, $urandom, $urandom, rand_state_value(), $urandom);
            added++;
         end else begin
            len = (cfg_steps <= 8) ? $urandom_range(0, cfg_steps + 2) : $urandom_range(1, 12);
            push_item(OP_START, $urandom, $urandom, rand_state_value(), $urandom);
            for (k = 0; k < len; k++)
               push_item(OP_STEP, $urandom, $urandom, $urandom, rand_uniform());
            added += len + 1;
         end
      end
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_states.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : run_phases
      int n, e;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: final mode, one step per chain, rows 0..4 hand built
      push_item(OP_WRITE_ENTRY, 0, 0, 1, 0);
      push_item(OP_WRITE_ENTRY, 1, 32768, 'hA02, 0);
      push_item(OP_WRITE_ENTRY, 2, 32768, 3, 0);
      push_item(OP_WRITE_ENTRY, 3, 65536, 'hF00, 0);
      push_item(OP_WRITE_ENTRY, 4, 1000, 0, 0);
      push_item(OP_WRITE_ENTRY, 5, 1000, 1, 0);
      push_item(OP_WRITE_ROW, 0, 0, 0, 0);
      push_item(OP_WRITE_ROW, 1, 0, 3, 0);
      push_item(OP_WRITE_ROW, 2, 0, 4, 0);
      push_item(OP_WRITE_ROW, 3, 0, 4, 0);
      push_item(OP_WRITE_ROW, 4, 0, 6, 0);
      // rows past the matrix are dropped
      push_item(OP_WRITE_ROW, MAX_STATES + 2, 0, 0, 0);
      push_item(OP_WRITE_ROW, 4095, 131071, 4095, 65535);
      // step before any start, then one past the chain length
      push_item(OP_STEP, 0, 0, 0, 0);
      push_item(OP_STEP, 4095, 131071, 4095, 5);
      push_item(OP_START, 0, 0, 'hF00, 0);
      push_item(OP_STEP, 0, 0, 0, 65535);
      // u above the row sum picks the last entry
      push_item(OP_START, 0, 0, 3, 0);
      push_item(OP_STEP, 0, 0, 0, 65535);
      // empty row keeps the state
      push_item(OP_START, 0, 0, 2, 0);
      push_item(OP_STEP, 0, 0, 0, 0);
      push_item(OP_START, 0, 0, 1, 0);
      push_item(OP_STEP, 0, 0, 0, 12345);
      drain();

      // smallest matrix: one state, one entry
      configure(1, 1, 3, 1);
      load_matrix(0, 1, 1, 1);
      queue_chains(40);
      drain();

      // full size settings, chains on the top states reaching the top entry, longest chains
      configure(256, 4096, 65535, 1);
      load_matrix(240, 256, 3, 4096);
      queue_chains(40);
      drain();

      // zero length chains: only starts give results
      configure(256, 4096, 0, 0);
      queue_chains(30);
      drain();

      repeat (3) begin
         n = $urandom_range(2, 16);
         e = $urandom_range(64, 4096);
         configure(n, e, $urandom_range(1, 6), $urandom_range(0, 1));
         load_matrix(0, n, 4, e);
         queue_chains(40);
         drain();
      end

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
